// ----- src/lm3d_pkg.sv -----
// Shared types and constants for the 3-D 26-neighbour local maximum detector.
`default_nettype none
package lm3d_pkg;

  localparam int ROW_LENGTH_W = 11;
  localparam int ROW_COUNT_W  = 16;
  localparam int CFG_DATA_W   = 16;
  localparam int RESULT_CNT_W = 26;
  localparam int TOTAL_W      = ROW_LENGTH_W + ROW_COUNT_W;
  localparam int FIELD_W      = 16;
  localparam int NEIGHBOURS   = 26;
  localparam int WIN_LANES    = NEIGHBOURS + 1;
  localparam int CENTER_LANE  = 13;

  localparam logic [ROW_LENGTH_W-1:0] ROW_LENGTH_RST = 11'd1024;
  localparam logic [ROW_COUNT_W-1:0]  ROW_COUNT_RST  = 16'd512;

  typedef enum logic {
    REG_ROW_LENGTH = 1'b0,
    REG_ROW_COUNT  = 1'b1
  } cfg_reg_t;

  // What the back end does with one queued item.
  typedef struct packed {
    logic flush;  // item past the last pixel: result only, no window update
    logic last;   // flush result closes the slice
    logic emit;   // pixel item gives a result
    logic judge;  // pixel result comes from the window test
  } item_ctl_t;

  localparam int CTL_W = $bits(item_ctl_t);

endpackage
`default_nettype wire

// ----- src/lm3d_fifo.sv -----
// Two-entry queue between the classifier and the window datapath.
`default_nettype none
module lm3d_fifo
  import lm3d_pkg::*;
#(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic                  not_empty,
  output logic [WIDTH-1:0]      head
);

  logic [WIDTH-1:0] ent_r [2];
  logic [WIDTH-1:0] ent_nxt [2];
  logic [1:0]       cnt_r, cnt_nxt;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign head      = ent_r[0];

  always_comb begin
    ent_nxt[0] = ent_r[0];
    ent_nxt[1] = ent_r[1];
    cnt_nxt    = cnt_r;
    if (pop) begin
      ent_nxt[0] = ent_r[1];
      cnt_nxt    = cnt_nxt - 2'd1;
    end
    if (push) begin
      if (cnt_nxt == 2'd0) begin
        ent_nxt[0] = push_data;
      end else begin
        ent_nxt[1] = push_data;
      end
      cnt_nxt = cnt_nxt + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    ent_r[0] <= ent_nxt[0];
    ent_r[1] <= ent_nxt[1];
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- src/lm3d_front.sv -----
// Front end: configuration registers, raster position tracking, item classification.
`default_nettype none
module lm3d_front
  import lm3d_pkg::*;
#(
  parameter int MAX_WIDTH   = 1024,
  parameter int SAMPLE_BITS = 16,
  parameter int XW          = $clog2(MAX_WIDTH),
  parameter int ITEM_W      = CTL_W + XW + 3 * SAMPLE_BITS
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_wr_en,
  input  wire logic                   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [FIELD_W-1:0]     in_prev_sample,
  input  wire logic [FIELD_W-1:0]     in_cur_sample,
  input  wire logic [FIELD_W-1:0]     in_next_sample,
  input  wire logic                   in_drain,
  output logic                        push,
  output logic [ITEM_W-1:0]           push_data,
  input  wire logic                   q_full
);

  logic [ROW_LENGTH_W-1:0] row_length_r;
  logic [ROW_COUNT_W-1:0]  row_count_r;
  logic [TOTAL_W-1:0]      total_r;
  logic [XW-1:0]           col_r, col_nxt;
  logic [ROW_COUNT_W-1:0]  row_r, row_nxt;
  logic [RESULT_CNT_W-1:0] res_r, res_nxt;

  logic [ROW_LENGTH_W-1:0] w_used;
  logic [ROW_COUNT_W-1:0]  h_used;
  logic                    accept;
  logic                    in_flush;
  logic                    last;
  logic                    row_done;
  item_ctl_t               ctl;
  logic [3*SAMPLE_BITS-1:0] packed_s;

  always_comb begin
    if (row_length_r == '0) begin
      w_used = ROW_LENGTH_W'(1);
    end else if (int'(row_length_r) > MAX_WIDTH) begin
      w_used = ROW_LENGTH_W'(MAX_WIDTH);
    end else begin
      w_used = row_length_r;
    end
  end

  assign h_used   = (row_count_r == '0) ? ROW_COUNT_W'(1) : row_count_r;
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign in_flush = (row_r >= h_used);
  assign last     = ({1'b0, res_r} + (RESULT_CNT_W + 1)'(1)) >= (RESULT_CNT_W + 1)'(total_r);
  assign row_done = (32'(col_r) + 32'd1) >= 32'(w_used);
  assign packed_s = {in_next_sample[SAMPLE_BITS-1:0], in_cur_sample[SAMPLE_BITS-1:0],
                     in_prev_sample[SAMPLE_BITS-1:0]};

  always_comb begin
    ctl.flush = in_flush;
    ctl.last  = in_flush && last;
    ctl.emit  = !in_flush && ((row_r >= ROW_COUNT_W'(2)) ||
                              (row_r == ROW_COUNT_W'(1) && col_r != '0));
    ctl.judge = !in_flush && (row_r >= ROW_COUNT_W'(2)) && (col_r >= XW'(2));
  end

  assign push      = accept && (in_flush || !in_drain);
  assign push_data = {ctl, col_r, packed_s};

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    res_nxt = res_r;
    if (accept) begin
      if (in_flush) begin
        if (last) begin
          col_nxt = '0;
          row_nxt = '0;
          res_nxt = '0;
        end else begin
          res_nxt = res_r + RESULT_CNT_W'(1);
        end
      end else if (!in_drain) begin
        if (ctl.emit) begin
          res_nxt = res_r + RESULT_CNT_W'(1);
        end
        if (row_done) begin
          col_nxt = '0;
          row_nxt = row_r + ROW_COUNT_W'(1);
        end else begin
          col_nxt = col_r + XW'(1);
        end
      end
    end
    if (cfg_wr_en) begin
      col_nxt = '0;
      row_nxt = '0;
      res_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    total_r <= TOTAL_W'(w_used) * TOTAL_W'(h_used);
    if (!rst_n) begin
      row_length_r <= ROW_LENGTH_RST;
      row_count_r  <= ROW_COUNT_RST;
      col_r        <= '0;
      row_r        <= '0;
      res_r        <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      res_r <= res_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_ROW_LENGTH: row_length_r <= cfg_wdata[ROW_LENGTH_W-1:0];
          REG_ROW_COUNT:  row_count_r  <= cfg_wdata[ROW_COUNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

// ----- src/lm3d_back.sv -----
// Back end: two row stores, 3x3 window of sample triples, 26-neighbour test, output register.
`default_nettype none
module lm3d_back
  import lm3d_pkg::*;
#(
  parameter int MAX_WIDTH   = 1024,
  parameter int SAMPLE_BITS = 16,
  parameter int XW          = $clog2(MAX_WIDTH),
  parameter int ITEM_W      = CTL_W + XW + 3 * SAMPLE_BITS
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_not_empty,
  input  wire logic [ITEM_W-1:0] q_head,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   out_is_maximum,
  output logic                   out_slice_end
);

  localparam int TW = 3 * SAMPLE_BITS;

  logic [TW-1:0] mem_old [MAX_WIDTH];
  logic [TW-1:0] mem_new [MAX_WIDTH];

  item_ctl_t     s1_ctl_r;
  logic [XW-1:0] s1_x_r;
  logic [TW-1:0] s1_pk_r;
  logic          s1_v_r;
  logic [TW-1:0] rd_old_r, rd_new_r;
  logic          fwd_r;
  logic [TW-1:0] fwd_old_r, fwd_new_r;
  logic [TW-1:0] win_r [9];
  logic [TW-1:0] win_nxt [9];
  logic          out_v_r, out_max_r, out_end_r;

  item_ctl_t     h_ctl;
  logic [XW-1:0] h_x;
  logic [TW-1:0] h_pk;
  logic [TW-1:0] eff_old, eff_new;
  logic          s1_result;
  logic          s1_adv;
  logic          s1_write;
  logic [SAMPLE_BITS-1:0]  lanes [WIN_LANES];
  logic [NEIGHBOURS-1:0]   gt, eq;
  logic                    is_max;

  assign {h_ctl, h_x, h_pk} = q_head;

  assign eff_old   = fwd_r ? fwd_old_r : rd_old_r;
  assign eff_new   = fwd_r ? fwd_new_r : rd_new_r;
  assign s1_result = s1_ctl_r.flush || s1_ctl_r.emit;
  assign s1_adv    = s1_v_r && (!s1_result || !out_v_r || !out_stall);
  assign s1_write  = s1_adv && !s1_ctl_r.flush;
  assign q_pop     = q_not_empty && (!s1_v_r || s1_adv);

  always_comb begin
    win_nxt[0] = win_r[1];
    win_nxt[1] = win_r[2];
    win_nxt[2] = eff_old;
    win_nxt[3] = win_r[4];
    win_nxt[4] = win_r[5];
    win_nxt[5] = eff_new;
    win_nxt[6] = win_r[7];
    win_nxt[7] = win_r[8];
    win_nxt[8] = s1_pk_r;
  end

  // Lane 3*k+p is plane p (prev, cur, next) of window entry k; centre is cur of entry 4.
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      for (int p = 0; p < 3; p++) begin
        lanes[3*k+p] = win_nxt[k][p*SAMPLE_BITS +: SAMPLE_BITS];
      end
    end
    for (int i = 0; i < NEIGHBOURS; i++) begin
      gt[i] = (i < CENTER_LANE) ? (lanes[i] > lanes[CENTER_LANE])
                                : (lanes[i+1] > lanes[CENTER_LANE]);
      eq[i] = (i < CENTER_LANE) ? (lanes[i] == lanes[CENTER_LANE])
                                : (lanes[i+1] == lanes[CENTER_LANE]);
    end
  end

  // No larger neighbour and at most one equal one.
  assign is_max = (gt == '0) && ((eq & (eq - NEIGHBOURS'(1))) == '0);

  always_ff @(posedge clk) begin
    if (s1_write) begin
      mem_old[s1_x_r] <= eff_new;
      mem_new[s1_x_r] <= s1_pk_r;
    end
    if (q_pop) begin
      rd_old_r <= mem_old[h_x];
      rd_new_r <= mem_new[h_x];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_ctl_r  <= h_ctl;
      s1_x_r    <= h_x;
      s1_pk_r   <= h_pk;
      fwd_r     <= s1_write && (s1_x_r == h_x);
      fwd_old_r <= eff_new;
      fwd_new_r <= s1_pk_r;
    end
    if (s1_write) begin
      for (int k = 0; k < 9; k++) begin
        win_r[k] <= win_nxt[k];
      end
    end
    if (s1_adv && s1_result) begin
      out_max_r <= !s1_ctl_r.flush && s1_ctl_r.judge && is_max;
      out_end_r <= s1_ctl_r.flush && s1_ctl_r.last;
    end
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (q_pop) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_adv && s1_result) begin
        out_v_r <= 1'b1;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_v_r;
  assign out_is_maximum = out_max_r;
  assign out_slice_end  = out_end_r;

endmodule
`default_nettype wire

// ----- src/local_maxima_3d_26_neighbour_top.sv -----
// Top level of the 3-D 26-neighbour local maximum detector.
// Usage:
//   Input channel (in_valid / in_stall): one raster-order pixel per transfer,
//   carrying the samples of the previous, current and next slice, or a drain
//   item. Drain items before the last pixel are dropped; after the last pixel
//   every transfer is a flush item and yields one result.
//   Result channel (out_valid / out_stall): zero or one result per input item,
//   is_maximum plus slice_end on the final result of the slice.
//   Config port: cfg_wr_en / cfg_index / cfg_wdata, index 0 row_length,
//   index 1 row_count; any write restarts the slice. Write only when idle.
// Throughput: one item per cycle while out_stall is low, set by the row
//   stores that are read and written once per pixel in the same cycle; a
//   two-entry queue decouples the classifier from the window datapath.
// Path: an item goes through the queue, the window stage and the output
//   register to out_valid; results trail pixels by one row plus one pixel.
// Reset: row_length 1024, row_count 512, position counters cleared. The row
//   stores are not cleared; no startup pass is needed.
// Stall: out_stall holds the output register; a result in the window stage
//   then holds, the queue fills and in_stall rises once it holds two items.
`default_nettype none
module local_maxima_3d_26_neighbour_top
  import lm3d_pkg::*;
#(
  parameter int MAX_WIDTH   = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wr_en,
  input  wire logic                  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [FIELD_W-1:0]    in_prev_sample,
  input  wire logic [FIELD_W-1:0]    in_cur_sample,
  input  wire logic [FIELD_W-1:0]    in_next_sample,
  input  wire logic                  in_drain,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       out_is_maximum,
  output logic                       out_slice_end
);

  localparam int XW     = $clog2(MAX_WIDTH);
  localparam int ITEM_W = CTL_W + XW + 3 * SAMPLE_BITS;

  logic              push, q_full, q_pop, q_not_empty;
  logic [ITEM_W-1:0] push_data, q_head;

  lm3d_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .SAMPLE_BITS(SAMPLE_BITS),
    .XW         (XW),
    .ITEM_W     (ITEM_W)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_prev_sample(in_prev_sample),
    .in_cur_sample (in_cur_sample),
    .in_next_sample(in_next_sample),
    .in_drain      (in_drain),
    .push          (push),
    .push_data     (push_data),
    .q_full        (q_full)
  );

  lm3d_fifo #(
    .WIDTH(ITEM_W)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(push_data),
    .full     (q_full),
    .pop      (q_pop),
    .not_empty(q_not_empty),
    .head     (q_head)
  );

  lm3d_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .SAMPLE_BITS(SAMPLE_BITS),
    .XW         (XW),
    .ITEM_W     (ITEM_W)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_not_empty   (q_not_empty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_is_maximum(out_is_maximum),
    .out_slice_end (out_slice_end)
  );

endmodule
`default_nettype wire

// ----- tb/tb_local_maxima_3d_26_neighbour_top.sv -----
// Testbench for the 3-D 26-neighbour local maximum detector: directed table plus random slices.
`timescale 1ns / 1ps
module tb_local_maxima_3d_26_neighbour_top;
  import lm3d_pkg::*;

  localparam int MAXW = 1024;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic is_max;
    logic slice_end;
  } mark_t;

  typedef struct {
    logic [15:0] prev_s;
    logic [15:0] cur_s;
    logic [15:0] next_s;
    logic        drain;
    logic        typed;    // expected result written in the row
    mark_t       mark;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic cfg_index = REG_ROW_LENGTH;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [FIELD_W-1:0] in_prev_sample = '0, in_cur_sample = '0, in_next_sample = '0;
  logic in_drain = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_is_maximum, out_slice_end;

  local_maxima_3d_26_neighbour_top dut (
    .clk, .rst_n, .cfg_wr_en, .cfg_index, .cfg_wdata,
    .in_valid, .in_stall, .in_prev_sample, .in_cur_sample, .in_next_sample, .in_drain,
    .out_valid, .out_stall, .out_is_maximum, .out_slice_end
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Detector state mirror
  logic [47:0] line_mem [2*MAXW];
  logic [47:0] win [9];
  int unsigned col_pos, row_pos, marks_given;
  logic [10:0] row_len_reg;
  logic [15:0] row_cnt_reg;

  mark_t pending_marks[$];
  int errors = 0;
  int send_pct = 0, stall_pct = 0;
  int items_sent = 0;
  longint cycles = 0;
  logic slice_done;

  function automatic logic center_is_peak();
    logic [15:0] c, v;
    int lower;
    c = win[4][31:16];
    lower = 0;
    for (int i = 0; i < 9; i++)
      for (int p = 0; p < 3; p++) begin
        if (i == 4 && p == 1) continue;
        v = win[i][16*p +: 16];
        if (v > c) return 1'b0;
        if (v < c) lower++;
      end
    return lower >= 25;
  endfunction

  task automatic restart_slice();
    col_pos = 0;
    row_pos = 0;
    marks_given = 0;
  endtask

  // Advance the mirror by one transferred item; returns whether a result is due.
  task automatic advance_window(input logic [15:0] ps, cs, ns, input logic dr,
                                output logic due, output mark_t m);
    int unsigned w, h, x, y;
    logic [47:0] packed_s;
    w = (row_len_reg == 0) ? 1 : (row_len_reg > MAXW ? MAXW : row_len_reg);
    h = (row_cnt_reg == 0) ? 1 : row_cnt_reg;
    due = 1'b0;
    m = '0;
    slice_done = 1'b0;
    if (row_pos >= h) begin
      due = 1'b1;
      m.slice_end = (marks_given + 1) >= w * h;
      if (m.slice_end) begin
        restart_slice();
        slice_done = 1'b1;
      end else marks_given++;
      return;
    end
    if (dr) return;
    x = col_pos;
    y = row_pos;
    packed_s = {ns, cs, ps};
    win[0] = win[1]; win[1] = win[2];
    win[3] = win[4]; win[4] = win[5];
    win[6] = win[7]; win[7] = win[8];
    win[2] = line_mem[x];
    win[5] = line_mem[MAXW + x];
    win[8] = packed_s;
    line_mem[x] = line_mem[MAXW + x];
    line_mem[MAXW + x] = packed_s;
    if (y >= 2 || (y == 1 && x >= 1)) begin
      due = 1'b1;
      m.is_max = (x >= 2 && y >= 2) ? center_is_peak() : 1'b0;
      marks_given++;
    end
    if (x + 1 >= w) begin
      col_pos = 0;
      row_pos = y + 1;
    end else col_pos = x + 1;
  endtask

  // Starts and ends at a falling edge; valid stays high for a following item.
  task automatic send_item(input logic [15:0] ps, cs, ns, input logic dr,
                           input logic typed, input mark_t typed_mark);
    logic due;
    mark_t m;
    if ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_prev_sample <= ps;
    in_cur_sample <= cs;
    in_next_sample <= ns;
    in_drain <= dr;
    do @(posedge clk); while (in_stall);
    advance_window(ps, cs, ns, dr, due, m);
    if (due) pending_marks.push_back(typed ? typed_mark : m);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
    in_valid <= 1'b0;
    wait (pending_marks.size() == 0);
    repeat (8) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == REG_ROW_LENGTH) row_len_reg = val[10:0];
    else row_cnt_reg = val;
    restart_slice();
  endtask

  // Pixels with narrow values to provoke peaks and ties; some drains and wide values.
  task automatic random_slice();
    logic [15:0] s[3];
    do begin
      for (int k = 0; k < 3; k++)
        s[k] = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4) * 16'h3FFF);
      send_item(s[0], s[1], s[2], $urandom_range(9) == 0, 1'b0, '0);
    end while (!slice_done);
  endtask

  // Leading part of a slice: pixels only, no drains.
  task automatic random_pixels(input int count);
    logic [15:0] s[3];
    for (int n = 0; n < count; n++) begin
      for (int k = 0; k < 3; k++)
        s[k] = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4) * 16'h3FFF);
      send_item(s[0], s[1], s[2], 1'b0, 1'b0, '0);
    end
  endtask

  task automatic random_phase(input int budget);
    int goal;
    goal = items_sent + budget;
    while (items_sent < goal) begin
      if ($urandom_range(1)) write_reg(REG_ROW_LENGTH, 16'($urandom_range(1, 9)));
      if ($urandom_range(1)) write_reg(REG_ROW_COUNT, 16'($urandom_range(1, 9)));
      random_slice();
    end
  endtask

  stim_row_t dir_rows[$];

  task automatic add_row(input logic [15:0] ps, cs, ns, input logic dr,
                         input logic typed, input logic mx, input logic se);
    stim_row_t r;
    r.prev_s = ps; r.cur_s = cs; r.next_s = ns; r.drain = dr;
    r.typed = typed; r.mark = '{mx, se};
    dir_rows.push_back(r);
  endtask

  always @(negedge clk)
    out_stall <= ($urandom_range(99) < stall_pct);

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_marks.size() == 0) begin
        $display("%0t: unexpected result expected none actual max=%0b end=%0b",
                 $realtime, out_is_maximum, out_slice_end);
        errors++;
      end else begin
        mark_t e;
        e = pending_marks.pop_front();
        if (out_is_maximum !== e.is_max) begin
          $display("%0t: is_maximum expected %0b actual %0b", $realtime, e.is_max,
                   out_is_maximum);
          errors++;
        end
        if (out_slice_end !== e.slice_end) begin
          $display("%0t: slice_end expected %0b actual %0b", $realtime, e.slice_end,
                   out_slice_end);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("local_maxima_3d_26_neighbour_top verification failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 2*MAXW; i++) line_mem[i] = '0;
    for (int i = 0; i < 9; i++) win[i] = '0;
    row_len_reg = ROW_LENGTH_RST;
    row_cnt_reg = ROW_COUNT_RST;
    restart_slice();

    // 3x3 slice: center peak with one tie, early drain ignored, flush marks typed
    add_row(16'hABCD, 16'h0000, 16'h5555, 1'b1, 1'b0, 1'b0, 1'b0);
    add_row(16'h0000, 16'hFFFF, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0);
    add_row(16'hFFFE, 16'h1234, 16'h0001, 1'b0, 1'b0, 1'b0, 1'b0);
    add_row(16'h0000, 16'hAAAA, 16'h5555, 1'b0, 1'b0, 1'b0, 1'b0);
    add_row(16'h7FFF, 16'h8000, 16'h0F0F, 1'b0, 1'b1, 1'b0, 1'b0);
    add_row(16'hFFFE, 16'hFFFF, 16'hFFFE, 1'b0, 1'b1, 1'b0, 1'b0);
    add_row(16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b1, 1'b0, 1'b0);
    add_row(16'h00FF, 16'hFF00, 16'hF0F0, 1'b0, 1'b1, 1'b0, 1'b0);
    add_row(16'h1111, 16'h2222, 16'h3333, 1'b0, 1'b1, 1'b0, 1'b0);
    add_row(16'h4444, 16'h5555, 16'h6666, 1'b0, 1'b0, 1'b0, 1'b0);
    add_row(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b0, 1'b0);
    add_row(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1, 1'b0, 1'b0);
    add_row(16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1, 1'b0, 1'b0);
    add_row(16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b1, 1'b0, 1'b1);
    // second slice: a greater neighbour in the next plane kills the peak
    add_row(16'h0100, 16'h0200, 16'h0300, 1'b0, 1'b0, 1'b0, 1'b0);
    add_row(16'h0100, 16'h0200, 16'h8001, 1'b0, 1'b0, 1'b0, 1'b0);
    add_row(16'h0100, 16'h0200, 16'h0300, 1'b0, 1'b0, 1'b0, 1'b0);
    add_row(16'h0100, 16'h0200, 16'h0300, 1'b0, 1'b0, 1'b0, 1'b0);
    add_row(16'h0100, 16'h8000, 16'h0300, 1'b0, 1'b0, 1'b0, 1'b0);
    add_row(16'h0100, 16'h0200, 16'h0300, 1'b0, 1'b0, 1'b0, 1'b0);
    add_row(16'h0100, 16'h0200, 16'h0300, 1'b0, 1'b0, 1'b0, 1'b0);
    add_row(16'h0100, 16'h0200, 16'h0300, 1'b0, 1'b0, 1'b0, 1'b0);
    add_row(16'h0100, 16'h0200, 16'h0300, 1'b0, 1'b0, 1'b0, 1'b0);
    add_row(16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b1, 1'b0, 1'b0);
    add_row(16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1, 1'b0, 1'b0);
    add_row(16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b1, 1'b0, 1'b0);
    add_row(16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1, 1'b0, 1'b1);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_reg(REG_ROW_LENGTH, 16'd3);
    write_reg(REG_ROW_COUNT, 16'd3);
    foreach (dir_rows[i])
      send_item(dir_rows[i].prev_s, dir_rows[i].cur_s, dir_rows[i].next_s,
                dir_rows[i].drain, dir_rows[i].typed, dir_rows[i].mark);

    send_pct = 12; stall_pct = 69;
    random_phase(300);
    send_pct = 69; stall_pct = 12;
    random_phase(300);
    send_pct = 0; stall_pct = 0;
    random_phase(300);

    // register extremes: out-of-range values clamp
    write_reg(REG_ROW_LENGTH, 16'd0);
    write_reg(REG_ROW_COUNT, 16'd0);
    random_slice();
    // width clamps to 1024: the second row starts giving results after 1025 pixels
    write_reg(REG_ROW_LENGTH, 16'hFFFF);
    write_reg(REG_ROW_COUNT, 16'd2);
    random_pixels(1030);
    write_reg(REG_ROW_LENGTH, 16'd1);
    write_reg(REG_ROW_COUNT, 16'd65535);
    random_pixels(6);

    in_valid <= 1'b0;
    wait (pending_marks.size() == 0);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("local_maxima_3d_26_neighbour_top verification clean");
    end else begin
      $display("local_maxima_3d_26_neighbour_top verification failed");
    end
    $finish;
  end

endmodule

// ----- local_maxima_3d_26_neighbour_top.f -----
src/lm3d_pkg.sv
src/lm3d_fifo.sv
src/lm3d_front.sv
src/lm3d_back.sv
src/local_maxima_3d_26_neighbour_top.sv
tb/tb_local_maxima_3d_26_neighbour_top.sv
